@@ rtl/pdce_pkg.sv @@
package pdce_pkg;

  localparam int MAX_ORBITALS_DEF = 16;
  localparam int IDX_W  = 4;
  localparam int VAL_W  = 32;
  localparam int RES_W  = 48;
  localparam int TOT_W  = 40;
  localparam int CFG_W  = 5;
  localparam int OP_W   = 3;
  localparam int KIND_W = 3;
  localparam int SCL_W  = CFG_W + 1;
  localparam int PRD_W  = VAL_W + SCL_W;

  localparam logic [CFG_W-1:0] ACTIVE_RST = 5'd16;
  localparam logic [CFG_W-1:0] ALPHA_RST  = 5'd1;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_D1 = 3'd0,
    OP_LOAD_D0 = 3'd1,
    OP_LOAD_M  = 3'd2,
    OP_QUERY   = 3'd3,
    OP_CLEAR   = 3'd4
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_TRACE_M  = 3'd0,
    KIND_TRACE_D0 = 3'd1,
    KIND_TRACE_D1 = 3'd2,
    KIND_ROW      = 3'd3,
    KIND_COL      = 3'd4,
    KIND_DIFF     = 3'd5,
    KIND_ANTI     = 3'd6,
    KIND_NONE     = 3'd7
  } kind_t;

  typedef enum logic {
    CFG_ACTIVE = 1'b0,
    CFG_ALPHA  = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic [KIND_W-1:0]        kind;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [VAL_W-1:0]  value;
  } cmd_t;

  typedef struct packed {
    logic signed [RES_W-1:0]  result;
    logic [KIND_W-1:0]        result_kind;
    logic [IDX_W-1:0]         result_row;
    logic [IDX_W-1:0]         result_col;
  } rsp_t;

  typedef struct packed {
    logic                     en;
    logic                     clr;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [VAL_W-1:0]  data;
  } mem_wr_t;

endpackage

@@ rtl/pdce_pair_mem.sv @@
module pdce_pair_mem
  import pdce_pkg::*;
#(
  parameter int MAX_ORBITALS = MAX_ORBITALS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  mem_wr_t                 wr,
  input  logic [IDX_W-1:0]        rd_row,
  input  logic [IDX_W-1:0]        rd_col,
  output logic signed [VAL_W-1:0] rd_a,
  output logic signed [VAL_W-1:0] rd_b
);

  localparam int NU    = (MAX_ORBITALS < 16) ? MAX_ORBITALS : 16;
  localparam int IW    = $clog2(NU);
  localparam int DEPTH = 2 ** (2 * IW);

  logic signed [VAL_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]        vld;
  logic [2*IW-1:0]         wa;
  logic [2*IW-1:0]         ra;
  logic [2*IW-1:0]         rb;

  assign wa = {wr.row[IW-1:0], wr.col[IW-1:0]};
  assign ra = {rd_row[IW-1:0], rd_col[IW-1:0]};
  assign rb = {rd_col[IW-1:0], rd_row[IW-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr.clr) begin
      vld <= '0;
    end else if (wr.en) begin
      vld[wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wa] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_a <= vld[ra] ? mem[ra] : '0;
    rd_b <= vld[rb] ? mem[rb] : '0;
  end

endmodule

@@ rtl/pdce_eval.sv @@
module pdce_eval
  import pdce_pkg::*;
#(
  parameter int MAX_ORBITALS = MAX_ORBITALS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cmd_vld,
  input  cmd_t                    cmd,
  input  logic [CFG_W-1:0]        active,
  input  logic [CFG_W-1:0]        alpha,
  input  logic signed [VAL_W-1:0] rd_a,
  input  logic signed [VAL_W-1:0] rd_b,
  output mem_wr_t                 mem_wr,
  output logic                    rsp_vld,
  output rsp_t                    rsp
);

  localparam int NU = (MAX_ORBITALS < 16) ? MAX_ORBITALS : 16;
  localparam int IW = $clog2(NU);

  logic signed [VAL_W-1:0] d1 [NU];
  logic signed [VAL_W-1:0] d0 [NU];
  logic signed [TOT_W-1:0] row_tot [NU];
  logic signed [TOT_W-1:0] col_tot [NU];
  logic signed [TOT_W-1:0] tr_m;
  logic signed [TOT_W-1:0] tr_d0;
  logic signed [TOT_W-1:0] tr_d1;
  mem_wr_t                 fwd;

  logic                    in_i;
  logic                    in_j;
  logic [IW-1:0]           ri;
  logic [IW-1:0]           ci;
  logic signed [VAL_W-1:0] d1_i;
  logic signed [VAL_W-1:0] d0_i;
  logic signed [TOT_W-1:0] rt_i;
  logic signed [TOT_W-1:0] ct_i;
  logic signed [VAL_W-1:0] m_ij;
  logic signed [VAL_W-1:0] m_ji;
  logic signed [TOT_W-1:0] dd1;
  logic signed [TOT_W-1:0] dd0;
  logic signed [TOT_W-1:0] dm;
  logic signed [SCL_W-1:0] scale;
  logic signed [PRD_W-1:0] prod;
  logic signed [RES_W-1:0] r;

  always_comb begin
    in_i  = ({1'b0, cmd.row} < active) && (32'(cmd.row) < MAX_ORBITALS);
    in_j  = ({1'b0, cmd.col} < active) && (32'(cmd.col) < MAX_ORBITALS);
    ri    = cmd.row[IW-1:0];
    ci    = (cmd.op == OP_LOAD_M) ? cmd.col[IW-1:0] : cmd.row[IW-1:0];
    d1_i  = d1[ri];
    d0_i  = d0[ri];
    rt_i  = row_tot[ri];
    ct_i  = col_tot[ci];
    // the memory read was taken at accept, so cover the write or clear of the word before
    if (fwd.clr) begin
      m_ij = '0;
      m_ji = '0;
    end else begin
      m_ij = (fwd.en && fwd.row == cmd.row && fwd.col == cmd.col) ? fwd.data : rd_a;
      m_ji = (fwd.en && fwd.row == cmd.col && fwd.col == cmd.row) ? fwd.data : rd_b;
    end
    dd1   = TOT_W'(cmd.value) - TOT_W'(d1_i);
    dd0   = TOT_W'(cmd.value) - TOT_W'(d0_i);
    dm    = TOT_W'(cmd.value) - TOT_W'(m_ij);
    scale = $signed({1'b0, alpha}) - SCL_W'(1);
    prod  = PRD_W'(d1_i) * PRD_W'(scale);
  end

  always_comb begin
    mem_wr.en   = cmd_vld && (cmd.op == OP_LOAD_M) && in_i && in_j;
    mem_wr.clr  = cmd_vld && (cmd.op == OP_CLEAR);
    mem_wr.row  = cmd.row;
    mem_wr.col  = cmd.col;
    mem_wr.data = cmd.value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= '0;
    end else begin
      fwd <= mem_wr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d1      <= '{default: '0};
      d0      <= '{default: '0};
      row_tot <= '{default: '0};
      col_tot <= '{default: '0};
      tr_m    <= '0;
      tr_d0   <= '0;
      tr_d1   <= '0;
    end else if (cmd_vld) begin
      unique case (cmd.op)
        OP_LOAD_D1: begin
          if (in_i) begin
            d1[ri] <= cmd.value;
            tr_d1  <= tr_d1 + dd1;
          end
        end
        OP_LOAD_D0: begin
          if (in_i) begin
            d0[ri] <= cmd.value;
            tr_d0  <= tr_d0 + dd0;
          end
        end
        OP_LOAD_M: begin
          if (in_i && in_j && (cmd.row != cmd.col)) begin
            tr_m        <= tr_m + dm;
            row_tot[ri] <= rt_i + dm;
            col_tot[ci] <= ct_i + dm;
          end
        end
        OP_CLEAR: begin
          d1      <= '{default: '0};
          d0      <= '{default: '0};
          row_tot <= '{default: '0};
          col_tot <= '{default: '0};
          tr_m    <= '0;
          tr_d0   <= '0;
          tr_d1   <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // magnitudes stay below 2^42, so the 48-bit range is never exceeded
  always_comb begin
    r = '0;
    unique case (cmd.kind)
      KIND_TRACE_M:  r = RES_W'(tr_m);
      KIND_TRACE_D0: r = RES_W'(tr_d0);
      KIND_TRACE_D1: r = RES_W'(tr_d1);
      KIND_ROW:      r = in_i ? RES_W'(prod) - RES_W'(rt_i) : '0;
      KIND_COL:      r = in_i ? RES_W'(prod) - RES_W'(ct_i) : '0;
      KIND_DIFF:     r = in_i ? RES_W'(d1_i) - RES_W'(d0_i) : '0;
      KIND_ANTI: begin
        if (in_i && in_j) begin
          r = (cmd.row == cmd.col) ? RES_W'(m_ij) : RES_W'(m_ij) - RES_W'(m_ji);
        end
      end
      default: r = '0;
    endcase
  end

  always_comb begin
    rsp_vld         = cmd_vld && (cmd.op == OP_QUERY) && (cmd.kind != KIND_NONE);
    rsp.result      = r;
    rsp.result_kind = cmd.kind;
    rsp.result_row  = (cmd.kind == KIND_TRACE_M || cmd.kind == KIND_TRACE_D0
                       || cmd.kind == KIND_TRACE_D1) ? '0 : cmd.row;
    rsp.result_col  = (cmd.kind == KIND_ANTI) ? cmd.col : '0;
  end

endmodule

@@ rtl/pair_density_constraint_eval_core.sv @@
// pair-density constraint evaluator
// command channel: present a word on cmd with start high; it is taken at a
//   rising edge where busy is low. op selects a one-particle load, a
//   seniority-zero diagonal load, a seniority-two matrix load, a query or a
//   clear. busy is low once the cycle after reset has passed, so one word per cycle.
// result channel: each query of a defined kind gives one word on rsp, marked
//   by valid for exactly one cycle. loads, clears and undefined words give
//   nothing. the receiver cannot stall, so results are never held.
// result path: a query is registered into the compute stage when it is taken,
//   and the matrix store is read at that same accepting edge. the compute stage
//   forms the value from that read, the small stores and the running totals,
//   and the output register rsp captures it, marked by valid.
// throughput: one word per cycle while busy is low, set by the single compute stage and the
//   two read ports of the matrix store.
// config: cfg_we with cfg_index 0 sets active_orbitals, 1 sets alpha_electrons;
//   write only while idle.
// reset: rst is synchronous; stores and totals read as zero, registers go
//   to 16 orbitals and 1 electron, busy is high during reset and in the cycle
//   after it.
module pair_density_constraint_eval_core
  import pdce_pkg::*;
#(
  parameter int MAX_ORBITALS = MAX_ORBITALS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             start,
  output logic             busy,
  input  cmd_t             cmd,
  output logic             valid,
  output rsp_t             rsp
);

  logic                    busy_q;
  logic [CFG_W-1:0]        active;
  logic [CFG_W-1:0]        alpha;
  logic                    s1_vld;
  cmd_t                    s1_cmd;
  logic                    accept;
  logic signed [VAL_W-1:0] rd_a;
  logic signed [VAL_W-1:0] rd_b;
  mem_wr_t                 mem_wr;
  logic                    rsp_vld;
  rsp_t                    rsp_next;

  assign busy   = rst | busy_q;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    busy_q <= rst;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= ACTIVE_RST;
      alpha  <= ALPHA_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ACTIVE: active <= cfg_data;
        CFG_ALPHA:  alpha  <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      valid  <= 1'b0;
    end else begin
      s1_vld <= accept;
      valid  <= rsp_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd <= cmd;
    end
    rsp <= rsp_next;
  end

  pdce_pair_mem #(
    .MAX_ORBITALS(MAX_ORBITALS)
  ) u_mem (
    .clk    (clk),
    .rst    (rst),
    .wr     (mem_wr),
    .rd_row (cmd.row),
    .rd_col (cmd.col),
    .rd_a   (rd_a),
    .rd_b   (rd_b)
  );

  pdce_eval #(
    .MAX_ORBITALS(MAX_ORBITALS)
  ) u_eval (
    .clk     (clk),
    .rst     (rst),
    .cmd_vld (s1_vld),
    .cmd     (s1_cmd),
    .active  (active),
    .alpha   (alpha),
    .rd_a    (rd_a),
    .rd_b    (rd_b),
    .mem_wr  (mem_wr),
    .rsp_vld (rsp_vld),
    .rsp     (rsp_next)
  );

`ifndef SYNTHESIS
  a_valid_from_query: assert property (@(posedge clk) disable iff (rst)
    valid |-> $past(s1_vld) && $past(s1_cmd.op) == OP_QUERY)
    else $error("result strobe without a query in the compute stage");

  a_no_result_for_load: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.op != OP_QUERY) |-> ##2 !valid)
    else $error("result strobe after a non-query word");

  a_wr_clr_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(mem_wr.en && mem_wr.clr))
    else $error("matrix store written and cleared together");
`endif

endmodule

@@ dv/testbench.sv @@
module testbench;
  import pdce_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
  localparam longint SAT_HI = (longint'(1) << (RES_W - 1)) - 1;
  localparam longint SAT_LO = -(longint'(1) << (RES_W - 1));

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic             cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic             start;
  logic             busy;
  cmd_t             cmd;
  logic             valid;
  rsp_t             rsp;

  pair_density_constraint_eval_core dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .valid(valid),
    .rsp(rsp)
  );

  // mirror of the block state
  longint d1_mem [MAX_ORBITALS_DEF];
  longint d0_mem [MAX_ORBITALS_DEF];
  longint m_mem [MAX_ORBITALS_DEF][MAX_ORBITALS_DEF];
  longint row_sum [MAX_ORBITALS_DEF];
  longint col_sum [MAX_ORBITALS_DEF];
  longint trace_sum [3];
  int     cfg_orbitals;
  int     cfg_electrons;

  rsp_t   pending_constraints [$];
  int     failures = 0;
  int     gap_hi = 12;
  bit     start_high = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("Test completed with failures");
    $finish;
  end

  task automatic wipe_stores();
    for (int a = 0; a < MAX_ORBITALS_DEF; a++) begin
      d1_mem[a] = 0;
      d0_mem[a] = 0;
      row_sum[a] = 0;
      col_sum[a] = 0;
      for (int b = 0; b < MAX_ORBITALS_DEF; b++) m_mem[a][b] = 0;
    end
    for (int t = 0; t < 3; t++) trace_sum[t] = 0;
  endtask

  task automatic apply_word(input cmd_t w, output bit produced, output rsp_t r);
    int     n;
    int     i;
    int     j;
    longint v;
    longint d;
    longint acc;
    longint scale;
    n = (cfg_orbitals < MAX_ORBITALS_DEF) ? cfg_orbitals : MAX_ORBITALS_DEF;
    i = w.row;
    j = w.col;
    v = w.value;
    scale = longint'(cfg_electrons) - 1;
    produced = 0;
    acc = 0;
    r = '0;
    case (w.op)
      OP_LOAD_D1: begin
        if (i < n) begin
          trace_sum[KIND_TRACE_D1] += v - d1_mem[i];
          d1_mem[i] = v;
        end
      end
      OP_LOAD_D0: begin
        if (i < n) begin
          trace_sum[KIND_TRACE_D0] += v - d0_mem[i];
          d0_mem[i] = v;
        end
      end
      OP_LOAD_M: begin
        if (i < n && j < n) begin
          d = v - m_mem[i][j];
          m_mem[i][j] = v;
          if (i != j) begin
            trace_sum[KIND_TRACE_M] += d;
            row_sum[i] += d;
            col_sum[j] += d;
          end
        end
      end
      OP_CLEAR: wipe_stores();
      OP_QUERY: begin
        if (w.kind != KIND_NONE) begin
          produced = 1;
          case (w.kind)
            KIND_TRACE_M, KIND_TRACE_D0, KIND_TRACE_D1: begin
              acc = trace_sum[w.kind];
              i = 0;
              j = 0;
            end
            KIND_ROW: begin
              j = 0;
              if (i < n) acc = scale * d1_mem[i] - row_sum[i];
            end
            KIND_COL: begin
              j = 0;
              if (i < n) acc = scale * d1_mem[i] - col_sum[i];
            end
            KIND_DIFF: begin
              j = 0;
              if (i < n) acc = d1_mem[i] - d0_mem[i];
            end
            default: begin
              if (i < n && j < n) acc = (i == j) ? m_mem[i][i] : m_mem[i][j] - m_mem[j][i];
            end
          endcase
          if (acc > SAT_HI) acc = SAT_HI;
          else if (acc < SAT_LO) acc = SAT_LO;
          r.result = acc[RES_W-1:0];
          r.result_kind = w.kind;
          r.result_row = i[IDX_W-1:0];
          r.result_col = j[IDX_W-1:0];
        end
      end
      default: ;
    endcase
  endtask

  function automatic cmd_t mk(int op, int kind, int row, int col,
                              logic [VAL_W-1:0] value);
    cmd_t c;
    c.op = op[OP_W-1:0];
    c.kind = kind[KIND_W-1:0];
    c.row = row[IDX_W-1:0];
    c.col = col[IDX_W-1:0];
    c.value = value;
    return c;
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 511) - 256;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_word(input cmd_t w);
    int   gap;
    bit   produced;
    rsp_t r;
    gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, gap_hi) : 0;
    if (gap > 0) begin
      if (start_high) begin
        start <= 1'b0;
        start_high = 0;
      end
      repeat (gap) @(posedge clk);
    end
    cmd <= w;
    start <= 1'b1;
    start_high = 1;
    do @(posedge clk); while (busy);
    apply_word(w, produced, r);
    if (produced) pending_constraints.push_back(r);
  endtask

  // idle: all results in, pipeline flushed
  task automatic settle();
    if (start_high) begin
      start <= 1'b0;
      start_high = 0;
    end
    while (pending_constraints.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input int orbitals, input int electrons);
    cfg_we <= 1'b1;
    cfg_index <= CFG_ACTIVE;
    cfg_data <= orbitals[CFG_W-1:0];
    @(posedge clk);
    cfg_index <= CFG_ALPHA;
    cfg_data <= electrons[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_orbitals = orbitals;
    cfg_electrons = electrons;
  endtask

  function automatic int rand_idx(int n, int in_pct);
    if ($urandom_range(0, 99) < in_pct) return $urandom_range(0, n - 1);
    return $urandom_range(0, MAX_ORBITALS_DEF - 1);
  endfunction

  // loads and queries within a clear, plus some noise
  function automatic cmd_t shaped_word(int n);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      case ($urandom_range(0, 2))
        0: return mk(OP_LOAD_D1, $urandom(), rand_idx(n, 100), $urandom(), pick_value());
        1: return mk(OP_LOAD_D0, $urandom(), rand_idx(n, 100), $urandom(), pick_value());
        default: return mk(OP_LOAD_M, $urandom(), rand_idx(n, 100), rand_idx(n, 100),
                           pick_value());
      endcase
    end
    if (pick < 88) begin
      return mk(OP_QUERY, $urandom_range(0, 6), rand_idx(n, 85), rand_idx(n, 85), $urandom());
    end
    return mk($urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 15),
              $urandom_range(0, 15), $urandom());
  endfunction

  task automatic test_directed_cases();
    send_word(mk(OP_QUERY, KIND_TRACE_M, 0, 0, 0));
    send_word(mk(OP_LOAD_D1, KIND_TRACE_M, 0, 0, 32'h7fff_ffff));
    send_word(mk(OP_LOAD_D1, KIND_TRACE_M, 15, 0, 32'h8000_0000));
    send_word(mk(OP_LOAD_D0, KIND_TRACE_M, 0, 0, 32'h8000_0000));
    send_word(mk(OP_LOAD_D0, KIND_TRACE_M, 15, 0, 32'h7fff_ffff));
    send_word(mk(OP_LOAD_M, KIND_TRACE_M, 0, 15, 32'h7fff_ffff));
    send_word(mk(OP_LOAD_M, KIND_TRACE_M, 15, 0, 32'h8000_0000));
    send_word(mk(OP_LOAD_M, KIND_TRACE_M, 3, 3, 32'h1234_5678));
    send_word(mk(OP_LOAD_M, KIND_TRACE_M, 0, 15, 32'h0000_0001));
    send_word(mk(OP_SPARE_LO, KIND_ROW, 2, 2, 32'h0000_0005));
    send_word(mk(OP_SPARE_HI, KIND_NONE, 15, 15, 32'hffff_ffff));
    for (int k = KIND_TRACE_M; k <= KIND_DIFF; k++) send_word(mk(OP_QUERY, k, 15, 9, 0));
    send_word(mk(OP_QUERY, KIND_ROW, 0, 0, 0));
    send_word(mk(OP_QUERY, KIND_ANTI, 0, 15, 0));
    send_word(mk(OP_QUERY, KIND_ANTI, 3, 3, 0));
    send_word(mk(OP_QUERY, KIND_NONE, 3, 3, 0));
    send_word(mk(OP_CLEAR, KIND_NONE, 15, 15, 32'hffff_ffff));
    send_word(mk(OP_QUERY, KIND_TRACE_D1, 0, 0, 0));
    settle();
    // small active range: out-of-range loads and queries
    set_config(4, 16);
    send_word(mk(OP_LOAD_D1, KIND_TRACE_M, 3, 0, 32'h7fff_ffff));
    send_word(mk(OP_LOAD_D1, KIND_TRACE_M, 4, 0, 32'h0100_0000));
    send_word(mk(OP_LOAD_M, KIND_TRACE_M, 2, 5, 32'h0100_0000));
    send_word(mk(OP_LOAD_M, KIND_TRACE_M, 3, 1, 32'h8000_0000));
    send_word(mk(OP_QUERY, KIND_ROW, 3, 7, 0));
    send_word(mk(OP_QUERY, KIND_COL, 1, 0, 0));
    send_word(mk(OP_QUERY, KIND_ROW, 9, 0, 0));
    send_word(mk(OP_QUERY, KIND_ANTI, 1, 7, 0));
    settle();
  endtask

  task automatic test_register_extremes();
    int orbs [4] = '{1, 16, 1, 16};
    int elec [4] = '{0, 16, 16, 0};
    for (int s = 0; s < 4; s++) begin
      settle();
      set_config(orbs[s], elec[s]);
      send_word(mk(OP_CLEAR, KIND_TRACE_M, 0, 0, 0));
      for (int k = 0; k < 40; k++) send_word(shaped_word(orbs[s]));
      for (int k = KIND_TRACE_M; k <= KIND_ANTI; k++)
        send_word(mk(OP_QUERY, k, rand_idx(orbs[s], 90), rand_idx(orbs[s], 90), 0));
    end
    settle();
  endtask

  task automatic test_totals_across_reconfig();
    set_config(16, 3);
    send_word(mk(OP_CLEAR, KIND_TRACE_M, 0, 0, 0));
    for (int k = 0; k < 24; k++) send_word(shaped_word(16));
    settle();
    set_config(2, 0);
    for (int k = KIND_TRACE_M; k <= KIND_ANTI; k++) send_word(mk(OP_QUERY, k, 1, 0, 0));
    send_word(mk(OP_QUERY, KIND_ROW, 5, 0, 0));
    settle();
    set_config(16, 0);
    for (int k = KIND_ROW; k <= KIND_ANTI; k++)
      send_word(mk(OP_QUERY, k, $urandom_range(0, 15), $urandom_range(0, 15), 0));
    settle();
  endtask

  task automatic test_random_traffic();
    int n;
    for (int blk = 0; blk < 10; blk++) begin
      settle();
      n = $urandom_range(1, 16);
      set_config(n, $urandom_range(0, 16));
      gap_hi = (blk % 3 == 1) ? 0 : 12;
      send_word(mk(OP_CLEAR, KIND_TRACE_M, 0, 0, 0));
      for (int k = 0; k < 100; k++) begin
        if (blk == 4 && k == 60) settle();
        send_word(shaped_word(n));
      end
    end
    gap_hi = 12;
    settle();
  endtask

  always @(posedge clk) begin : result_check
    rsp_t want;
    if (!rst && valid) begin
      if (pending_constraints.size() == 0) begin
        $error("unexpected word: result %0d kind %0d", rsp.result, rsp.result_kind);
        failures++;
      end else begin
        want = pending_constraints.pop_front();
        if (rsp.result !== want.result) begin
          $error("result: expected %0d actual %0d", want.result, rsp.result);
          failures++;
        end
        if (rsp.result_kind !== want.result_kind) begin
          $error("result_kind: expected %0d actual %0d", want.result_kind, rsp.result_kind);
          failures++;
        end
        if (rsp.result_row !== want.result_row) begin
          $error("result_row: expected %0d actual %0d", want.result_row, rsp.result_row);
          failures++;
        end
        if (rsp.result_col !== want.result_col) begin
          $error("result_col: expected %0d actual %0d", want.result_col, rsp.result_col);
          failures++;
        end
      end
    end
  end

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= CFG_ACTIVE;
    cfg_data <= '0;
    start <= 1'b0;
    cmd <= '0;
    wipe_stores();
    cfg_orbitals = ACTIVE_RST;
    cfg_electrons = ALPHA_RST;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_register_extremes();
    test_totals_across_reconfig();
    test_random_traffic();
    settle();
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/pdce_pkg.sv
rtl/pdce_pair_mem.sv
rtl/pdce_eval.sv
rtl/pair_density_constraint_eval_core.sv
dv/testbench.sv
